@@ rtl/core/pidr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidr_pkg - shared types, constants and saturating helpers
// Q16.16 number format, register indexes, multiplier shift codes and
// the saturate / magnitude-to-signed functions used by the datapath.
// ----------------------------------------------------------------------------
package pidr_pkg;

	localparam int DW      = 32;            // data word
	localparam int FRAC    = 16;            // fraction bits
	localparam int MAG_W   = DW + FRAC;     // magnitude of a scaled product or dividend
	localparam int MUL_LAT = 3;             // shared multiplier latency in cycles

	typedef logic signed [DW-1:0] q_t;      // signed Q16.16
	typedef logic        [DW-2:0] uq_t;     // unsigned period / time constant
	typedef logic        [MAG_W-1:0] mag_t;

	localparam q_t Q_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam q_t Q_MIN = {1'b1, {(DW-1){1'b0}}};

	// configuration register indexes
	localparam int REG_IDX_W = 3;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_GAIN_P   = 3'd0;
	localparam reg_idx_t REG_GAIN_I   = 3'd1;
	localparam reg_idx_t REG_GAIN_D   = 3'd2;
	localparam reg_idx_t REG_TAU      = 3'd3;
	localparam reg_idx_t REG_FLOOR    = 3'd4;
	localparam reg_idx_t REG_CEILING  = 3'd5;
	localparam reg_idx_t REG_PERIOD   = 3'd6;

	// register reset values
	localparam q_t  RST_GAIN_P  = 32'sd65536;
	localparam q_t  RST_GAIN_I  = 32'sd0;
	localparam q_t  RST_GAIN_D  = 32'sd0;
	localparam uq_t RST_TAU     = 31'd655;
	localparam q_t  RST_FLOOR   = -32'sd65536;
	localparam q_t  RST_CEILING = 32'sd65536;
	localparam uq_t RST_PERIOD  = 31'd7;

	// product scaling: by FRAC, by FRAC-1 (doubled term), by FRAC+1 (halved term)
	typedef enum logic [1:0] {
		SHR_FRAC,
		SHR_FRAC_LO,
		SHR_FRAC_HI
	} shr_t;

	function automatic q_t sat_add(input q_t a, input q_t b);
		logic [DW:0] s;
		s = {a[DW-1], a} + {b[DW-1], b};
		if (s[DW] != s[DW-1])
			sat_add = s[DW] ? Q_MIN : Q_MAX;
		else
			sat_add = s[DW-1:0];
	endfunction

	function automatic q_t sat_sub(input q_t a, input q_t b);
		logic [DW:0] s;
		s = {a[DW-1], a} - {b[DW-1], b};
		if (s[DW] != s[DW-1])
			sat_sub = s[DW] ? Q_MIN : Q_MAX;
		else
			sat_sub = s[DW-1:0];
	endfunction

	// sign and magnitude back to a saturated signed word
	function automatic q_t from_mag(input logic neg, input mag_t m);
		logic big;
		logic [DW-1:0] lo;
		big = |m[MAG_W-1:DW-1];
		lo  = m[DW-1:0];
		if (neg)
			from_mag = big ? Q_MIN : q_t'(-lo);
		else
			from_mag = big ? Q_MAX : q_t'(lo);
	endfunction

	function automatic logic [DW-1:0] magn(input q_t a);
		magn = a[DW-1] ? (~a + 1'b1) : a;
	endfunction

endpackage

@@ rtl/core/pidr_channels.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidr_channels - valid/ready channels of the regulator
// Input channel carries one sample item, output channel one drive item.
// ----------------------------------------------------------------------------
interface pidr_in_if;
	logic           valid;
	logic           ready;
	pidr_pkg::q_t   target;
	pidr_pkg::q_t   measured;
	pidr_pkg::uq_t  new_period;
	logic           hold_integrator;

	modport source (output valid, output target, output measured,
		output new_period, output hold_integrator, input ready);
	modport sink (input valid, input target, input measured,
		input new_period, input hold_integrator, output ready);
endinterface

interface pidr_out_if;
	logic           valid;
	logic           ready;
	pidr_pkg::q_t   drive;

	modport source (output valid, output drive, input ready);
	modport sink (input valid, input drive, output ready);
endinterface

@@ rtl/core/pid_regulator_step_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_regulator_step_unit - fixed-point PID regulator, one step per item
// Sequencer, configuration and state registers around a shared multiplier
// and an iterative divider.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : valid/ready sink; one item = target, measured, new_period,
//            hold_integrator. A non-zero new_period replaces the stored one.
//   out_ch : valid/ready source; one drive item per input item.
//   cfg_*  : write-only registers, written while no item is in flight.
//            A write of default_period only loads the working period.
// Timing: an item is accepted only while the sequencer is idle. The drive
//   item is offered after eleven sequencer steps feeding five products
//   through the three-stage multiplier, the iterative divider of the
//   derivative filter (started in the ninth step), then one output step.
//   The next item is taken the cycle after the result is registered, so a
//   new item is not worked on before the last drive item is registered.
// Stalls: the drive item sits in an output register; a new item is worked
//   on meanwhile and waits in its last step until that register frees.
// Reset: registers take their defaults, the filter and integrator state
//   clears and the output register empties.
// ----------------------------------------------------------------------------
module pid_regulator_step_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	pidr_in_if.sink                     in_ch,
	pidr_out_if.source                  out_ch,
	input  logic                        cfg_we,
	input  pidr_pkg::reg_idx_t          cfg_index,
	input  logic [pidr_pkg::DW-1:0]     cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	// step schedule; capture steps follow issue steps by the multiplier latency
	localparam logic [3:0] STP_PREP  = 4'd0;
	localparam logic [3:0] STP_P     = 4'd1;
	localparam logic [3:0] STP_K     = 4'd2;
	localparam logic [3:0] STP_C     = 4'd3;
	localparam logic [3:0] STP_DM    = 4'd4;
	localparam logic [3:0] STP_PROP  = 4'(STP_P + pidr_pkg::MUL_LAT);
	localparam logic [3:0] STP_INC   = 4'(STP_K + pidr_pkg::MUL_LAT);
	localparam logic [3:0] STP_WIN   = 4'(STP_PROP + 1);
	localparam logic [3:0] STP_CT    = 4'(STP_C + pidr_pkg::MUL_LAT);
	localparam logic [3:0] STP_NUM   = 4'(STP_DM + pidr_pkg::MUL_LAT);
	localparam logic [3:0] STP_ISUM  = 4'(STP_INC + pidr_pkg::MUL_LAT);
	localparam logic [3:0] STP_CLAMP = 4'(STP_ISUM + 1);
	localparam logic [3:0] STP_LAST  = 4'(STP_CLAMP + 1);

	logic [1:0]          state_q;
	logic [3:0]          step_q;

	// configuration
	pidr_pkg::q_t        gain_p_q, gain_i_q, gain_d_q, floor_q, ceil_q;
	pidr_pkg::uq_t       tau_q, period_q;

	// regulator state
	pidr_pkg::q_t        integral_q, last_err_q, slope_q, last_meas_q;

	// per-item working registers
	pidr_pkg::q_t        target_q, measured_q, err_q, dm_q, esum_q, two_tau_q;
	pidr_pkg::q_t        coef_q, prop_q, up_q, dn_q, cterm_q, num_q, isum_q;
	pidr_pkg::q_t        pi_q, sum_q;
	pidr_pkg::uq_t       den_q;
	logic                hold_q;

	logic                out_valid_q;
	pidr_pkg::q_t        drive_q;

	pidr_pkg::q_t        mul_a, mul_b, mul_p, period_s, div_quot, slope_new;
	pidr_pkg::shr_t      mul_shr;
	logic                div_start, div_done, in_take;

	assign in_ch.ready    = (state_q == ST_IDLE);
	assign in_take        = in_ch.valid && (state_q == ST_IDLE);
	assign out_ch.valid   = out_valid_q;
	assign out_ch.drive   = drive_q;
	assign period_s       = {1'b0, period_q};
	assign div_start      = (state_q == ST_RUN) && (step_q == STP_ISUM);
	assign slope_new      = (den_q == '0) ? '0 : div_quot;

	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_shr = pidr_pkg::SHR_FRAC;
		case (step_q)
			STP_P: begin
				mul_a = gain_p_q;
				mul_b = err_q;
			end
			STP_K: begin
				mul_a = gain_i_q;
				mul_b = period_s;
			end
			STP_C: begin
				mul_a = coef_q;
				mul_b = slope_q;
			end
			STP_DM: begin
				mul_a   = gain_d_q;
				mul_b   = dm_q;
				mul_shr = pidr_pkg::SHR_FRAC_LO;
			end
			STP_INC: begin
				mul_a   = mul_p;
				mul_b   = esum_q;
				mul_shr = pidr_pkg::SHR_FRAC_HI;
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	pidr_mul_unit u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.shr (mul_shr),
		.p   (mul_p)
	);

	pidr_div_unit u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// sequencer, configuration and regulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			out_valid_q  <= 1'b0;
			gain_p_q     <= pidr_pkg::RST_GAIN_P;
			gain_i_q     <= pidr_pkg::RST_GAIN_I;
			gain_d_q     <= pidr_pkg::RST_GAIN_D;
			tau_q        <= pidr_pkg::RST_TAU;
			floor_q      <= pidr_pkg::RST_FLOOR;
			ceil_q       <= pidr_pkg::RST_CEILING;
			period_q     <= pidr_pkg::RST_PERIOD;
			integral_q   <= '0;
			last_err_q   <= '0;
			slope_q      <= '0;
			last_meas_q  <= '0;
		end else begin
			if (state_q == ST_FIN && (!out_valid_q || out_ch.ready))
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;

			if (cfg_we) begin
				case (cfg_index)
					pidr_pkg::REG_GAIN_P:  gain_p_q <= cfg_data;
					pidr_pkg::REG_GAIN_I:  gain_i_q <= cfg_data;
					pidr_pkg::REG_GAIN_D:  gain_d_q <= cfg_data;
					pidr_pkg::REG_TAU:     tau_q    <= cfg_data[pidr_pkg::DW-2:0];
					pidr_pkg::REG_FLOOR:   floor_q  <= cfg_data;
					pidr_pkg::REG_CEILING: ceil_q   <= cfg_data;
					default: ;
				endcase
			end

			// default_period only ever loads the working period
			if (cfg_we && cfg_index == pidr_pkg::REG_PERIOD)
				period_q <= cfg_data[pidr_pkg::DW-2:0];
			else if (in_take && in_ch.new_period != '0)
				period_q <= in_ch.new_period;

			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						step_q  <= STP_PREP;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == STP_CLAMP) begin
						if (!hold_q) begin
							// ceiling test first, so inverted limits behave as specified
							if (isum_q > up_q)
								integral_q <= up_q;
							else if (isum_q < dn_q)
								integral_q <= dn_q;
							else
								integral_q <= isum_q;
						end
						last_err_q  <= err_q;
						last_meas_q <= measured_q;
					end
					if (step_q == STP_LAST)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						slope_q <= slope_new;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || out_ch.ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		if (in_take) begin
			target_q   <= in_ch.target;
			measured_q <= in_ch.measured;
			hold_q     <= in_ch.hold_integrator;
		end
		if (state_q == ST_RUN) begin
			case (step_q)
				STP_PREP: begin
					err_q     <= pidr_pkg::sat_sub(target_q, measured_q);
					dm_q      <= pidr_pkg::sat_sub(measured_q, last_meas_q);
					two_tau_q <= pidr_pkg::sat_add({1'b0, tau_q}, {1'b0, tau_q});
				end
				STP_P: begin
					esum_q <= pidr_pkg::sat_add(err_q, last_err_q);
					coef_q <= pidr_pkg::sat_sub(two_tau_q, period_s);
					// both operands are non-negative, so the sum is too
					den_q  <= pidr_pkg::uq_t'(pidr_pkg::sat_add(two_tau_q, period_s));
				end
				STP_PROP: prop_q <= mul_p;
				STP_WIN: begin
					up_q <= (ceil_q > prop_q) ? pidr_pkg::sat_sub(ceil_q, prop_q) : '0;
					dn_q <= (floor_q < prop_q) ? pidr_pkg::sat_sub(floor_q, prop_q) : '0;
				end
				STP_CT:   cterm_q <= mul_p;
				STP_NUM:  num_q   <= pidr_pkg::sat_sub(cterm_q, mul_p);
				STP_ISUM: isum_q  <= pidr_pkg::sat_add(integral_q, mul_p);
				STP_LAST: pi_q    <= pidr_pkg::sat_add(prop_q, integral_q);
				default: ;
			endcase
		end
		if (state_q == ST_DIV && div_done)
			sum_q <= pidr_pkg::sat_add(pi_q, slope_new);
		if (state_q == ST_FIN && (!out_valid_q || out_ch.ready)) begin
			if (sum_q > ceil_q)
				drive_q <= ceil_q;
			else if (sum_q < floor_q)
				drive_q <= floor_q;
			else
				drive_q <= sum_q;
		end
	end

endmodule

@@ rtl/core/pidr_mul_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidr_mul_unit - shared fixed-point multiplier
// Three-stage pipeline: magnitudes, 32x32 product, round half away from
// zero with a selectable right shift and saturation. Accepts an operand
// pair every cycle.
// ----------------------------------------------------------------------------
module pidr_mul_unit (
	input  logic                  clk,
	input  pidr_pkg::q_t          a,
	input  pidr_pkg::q_t          b,
	input  pidr_pkg::shr_t        shr,
	output pidr_pkg::q_t          p
);

	logic                          neg_s1, neg_s2;
	logic [pidr_pkg::DW-1:0]       ma_s1, mb_s1;
	pidr_pkg::shr_t                shr_s1, shr_s2;
	logic [2*pidr_pkg::DW-1:0]     prod_s2;
	pidr_pkg::q_t                  p_s3;
	logic [2*pidr_pkg::DW-1:0]     scaled;

	always_ff @(posedge clk) begin
		neg_s1  <= a[pidr_pkg::DW-1] ^ b[pidr_pkg::DW-1];
		ma_s1   <= pidr_pkg::magn(a);
		mb_s1   <= pidr_pkg::magn(b);
		shr_s1  <= shr;
		prod_s2 <= ma_s1 * mb_s1;
		neg_s2  <= neg_s1;
		shr_s2  <= shr_s1;
		p_s3    <= pidr_pkg::from_mag(neg_s2, scaled[pidr_pkg::MAG_W-1:0]);
	end

	// product magnitude is at most 2^62, so the rounding add cannot carry out
	always_comb begin
		case (shr_s2)
			pidr_pkg::SHR_FRAC:
				scaled = (prod_s2 + (64'd1 << (pidr_pkg::FRAC - 1))) >> pidr_pkg::FRAC;
			pidr_pkg::SHR_FRAC_LO:
				scaled = (prod_s2 + (64'd1 << (pidr_pkg::FRAC - 2))) >> (pidr_pkg::FRAC - 1);
			pidr_pkg::SHR_FRAC_HI:
				scaled = (prod_s2 + (64'd1 << pidr_pkg::FRAC)) >> (pidr_pkg::FRAC + 1);
			default:
				scaled = '0;
		endcase
	end

	assign p = p_s3;

endmodule

@@ rtl/core/pidr_div_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidr_div_unit - iterative fixed-point divider
// (num << FRAC) / den, truncated toward zero and saturated. Restoring
// division, two quotient bits per cycle over the 48-bit dividend.
// ----------------------------------------------------------------------------
module pidr_div_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  pidr_pkg::q_t   num,
	input  pidr_pkg::uq_t  den,
	output logic           done,
	output pidr_pkg::q_t   quot
);

	localparam int DIV_STEPS = pidr_pkg::MAG_W / 2;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

	logic                       busy_q, done_q, neg_q;
	logic [CNT_W-1:0]           cnt_q;
	pidr_pkg::uq_t              d_q, rem_q;
	pidr_pkg::mag_t             quo_q;

	logic [pidr_pkg::DW-1:0]    r1, r2, r1_sub, r2_sub;
	logic                       ge1, ge2;
	pidr_pkg::uq_t              r1s, r2s;
	pidr_pkg::mag_t             q1, q2;
	logic [pidr_pkg::DW-1:0]    mag;

	assign mag = pidr_pkg::magn(num);

	always_comb begin
		r1     = {rem_q, quo_q[pidr_pkg::MAG_W-1]};
		r1_sub = r1 - {1'b0, d_q};
		ge1    = r1 >= {1'b0, d_q};
		r1s    = ge1 ? r1_sub[pidr_pkg::DW-2:0] : r1[pidr_pkg::DW-2:0];
		q1     = {quo_q[pidr_pkg::MAG_W-2:0], ge1};
		r2     = {r1s, q1[pidr_pkg::MAG_W-1]};
		r2_sub = r2 - {1'b0, d_q};
		ge2    = r2 >= {1'b0, d_q};
		r2s    = ge2 ? r2_sub[pidr_pkg::DW-2:0] : r2[pidr_pkg::DW-2:0];
		q2     = {q1[pidr_pkg::MAG_W-2:0], ge2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in from the bottom as dividend bits leave the top
	always_ff @(posedge clk) begin
		if (start) begin
			d_q   <= den;
			rem_q <= '0;
			quo_q <= {mag, {pidr_pkg::FRAC{1'b0}}};
			neg_q <= num[pidr_pkg::DW-1];
		end else if (busy_q) begin
			rem_q <= r2s;
			quo_q <= q2;
		end
	end

	assign done = done_q;
	assign quot = pidr_pkg::from_mag(neg_q, quo_q);

endmodule

@@ test/pid_regulator_step_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_regulator_step_unit_test - self-checking bench for the PID step unit
// A directed plan (corner samples, every register, inverted limits, extreme
// periods) is followed by randomised phases, each with fresh register values.
// Every accepted sample is run through a local fixed-point model of the
// regulator and the drive items are compared in order as they come out.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module pid_regulator_step_unit_test;
	import pidr_pkg::*;

	typedef longint unsigned u64_t;

	typedef struct packed {
		q_t   target;
		q_t   measured;
		uq_t  new_period;
		logic hold;
	} sample_t;

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t      kind;
		reg_idx_t       idx;
		logic [DW-1:0]  data;
		q_t             target;
		q_t             measured;
		uq_t            new_period;
		logic           hold;
		logic           typed;
		q_t             drive;
	} plan_row_t;

	// index past the register file; writes there must be ignored
	localparam reg_idx_t REG_SPARE = 3'd7;

	localparam int PLAN_LEN        = 30;
	localparam int PHASES          = 12;
	localparam int ITEMS_PER_PHASE = 153;
	localparam int SETTLE_CYCLES   = 4;
	localparam int DRAIN_CYCLES    = 60;
	// upper bound for a run of ~1850 items
	localparam int CYCLE_LIMIT     = 600000;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	reg_idx_t cfg_index;
	logic [DW-1:0] cfg_data;

	pidr_in_if  in_ch ();
	pidr_out_if out_ch ();

	pid_regulator_step_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	int cycle_count = 0;
	int mismatches = 0;
	int src_gap_max = 8;
	int sink_stall_max = 8;
	q_t drive_queue [$];

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("pid_regulator_step_unit_test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// regulator model: registers and loop state
	// ------------------------------------------------------------------
	q_t kp, ki, kd, floor_s, ceil_s;
	uq_t tau_s;
	q_t integ_acc, prev_err, slope_acc, prev_meas, period_cur;

	function automatic q_t clip_q(input longint v);
		if (v > longint'(Q_MAX))
			return Q_MAX;
		if (v < longint'(Q_MIN))
			return Q_MIN;
		return q_t'(v);
	endfunction

	function automatic q_t add_q(input q_t a, input q_t b);
		return clip_q(longint'(a) + longint'(b));
	endfunction

	function automatic q_t sub_q(input q_t a, input q_t b);
		return clip_q(longint'(a) - longint'(b));
	endfunction

	function automatic q_t signed_from_mag(input logic neg, input u64_t m);
		if (neg)
			return (m >= 64'h8000_0000) ? Q_MIN : q_t'(-longint'(m));
		return (m > 64'h7fff_ffff) ? Q_MAX : q_t'(m);
	endfunction

	// exact product, shifted down with round half away from zero
	function automatic q_t scaled_product(input longint a, input longint b, input int sh);
		u64_t m;
		logic neg;
		neg = (a < 0) != (b < 0);
		m = u64_t'(a < 0 ? -a : a) * u64_t'(b < 0 ? -b : b);
		m = (m + (u64_t'(1) << (sh - 1))) >> sh;
		return signed_from_mag(neg, m);
	endfunction

	// (n << FRAC) / d, truncated toward zero; d is positive
	function automatic q_t filter_quotient(input q_t n, input q_t d);
		u64_t m;
		m = u64_t'(n < 0 ? -longint'(n) : longint'(n)) << FRAC;
		return signed_from_mag(n < 0, m / u64_t'(longint'(d)));
	endfunction

	function automatic q_t step_model(input sample_t smp);
		q_t err, prop, k, inc, up, dn, two_tau, den, coef, num, drv;
		if (smp.new_period != '0)
			period_cur = q_t'({1'b0, smp.new_period});
		err = sub_q(smp.target, smp.measured);
		prop = scaled_product(kp, err, FRAC);
		if (!smp.hold) begin
			k = scaled_product(ki, period_cur, FRAC);
			inc = scaled_product(k, add_q(err, prev_err), FRAC + 1);
			// anti-windup window follows the proportional term
			up = (ceil_s > prop) ? sub_q(ceil_s, prop) : q_t'(0);
			dn = (floor_s < prop) ? sub_q(floor_s, prop) : q_t'(0);
			integ_acc = add_q(integ_acc, inc);
			if (integ_acc > up)
				integ_acc = up;
			else if (integ_acc < dn)
				integ_acc = dn;
		end
		two_tau = add_q(q_t'({1'b0, tau_s}), q_t'({1'b0, tau_s}));
		den = add_q(two_tau, period_cur);
		coef = sub_q(two_tau, period_cur);
		num = sub_q(scaled_product(coef, slope_acc, FRAC),
			scaled_product(kd, sub_q(smp.measured, prev_meas), FRAC - 1));
		slope_acc = (den > 0) ? filter_quotient(num, den) : q_t'(0);
		drv = add_q(add_q(prop, integ_acc), slope_acc);
		if (drv > ceil_s)
			drv = ceil_s;
		else if (drv < floor_s)
			drv = floor_s;
		prev_err = err;
		prev_meas = smp.measured;
		return drv;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic write_reg(input reg_idx_t idx, input logic [DW-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			REG_GAIN_P: kp = value;
			REG_GAIN_I: ki = value;
			REG_GAIN_D: kd = value;
			REG_TAU: tau_s = value[DW-2:0];
			REG_FLOOR: floor_s = value;
			REG_CEILING: ceil_s = value;
			REG_PERIOD: period_cur = q_t'({1'b0, value[DW-2:0]});
			default: ;
		endcase
	endtask

	task automatic send_sample(input sample_t smp, input logic typed, input q_t typed_drive);
		int gap;
		q_t predicted;
		gap = $urandom_range(0, src_gap_max);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.target <= smp.target;
		in_ch.measured <= smp.measured;
		in_ch.new_period <= smp.new_period;
		in_ch.hold_integrator <= smp.hold;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		predicted = step_model(smp);
		drive_queue.push_back(typed ? typed_drive : predicted);
	endtask

	// hold the input until every drive item is back and the unit is idle
	task automatic settle_block();
		in_ch.valid <= 1'b0;
		cfg_we <= 1'b0;
		while (drive_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic q_t pick_level();
		case ($urandom_range(0, 15))
			0, 1: return q_t'($urandom());
			2: return Q_MAX;
			3: return Q_MIN;
			default: return q_t'($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
		endcase
	endfunction

	function automatic sample_t random_sample();
		sample_t smp;
		smp.target = pick_level();
		case ($urandom_range(0, 7))
			0: smp.measured = smp.target;
			1, 2, 3: smp.measured = smp.target + q_t'($urandom_range(0, 4096)) - 32'sd2048;
			default: smp.measured = pick_level();
		endcase
		case ($urandom_range(0, 9))
			6, 7, 8: smp.new_period = uq_t'($urandom_range(1, 32'h2_0000));
			9: smp.new_period = uq_t'($urandom());
			default: smp.new_period = '0;
		endcase
		smp.hold = ($urandom_range(0, 3) == 0);
		return smp;
	endfunction

	function automatic logic [DW-1:0] pick_gain();
		case ($urandom_range(0, 7))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0;
			default: return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
		endcase
	endfunction

	function automatic logic [DW-1:0] pick_tau();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'hffff_ffff;
			default: return $urandom_range(0, 32'h10_0000);
		endcase
	endfunction

	function automatic logic [DW-1:0] pick_period();
		case ($urandom_range(0, 7))
			0: return 32'h1;
			1: return 32'h7fff_ffff;
			2: return $urandom() | 32'h1;
			default: return $urandom_range(1, 32'h2_0000);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// directed plan; drive typed in only where it is obvious
	// ------------------------------------------------------------------
	plan_row_t plan [PLAN_LEN] = '{
		'{ROW_ITEM,  REG_GAIN_P,  32'h0, 32'sd0, 32'sd0, 31'd0, 1'b0, 1'b1, 32'sd0},
		'{ROW_ITEM,  REG_GAIN_P,  32'h0, 32'sh7fff_ffff, 32'sh8000_0000, 31'd0, 1'b0,
			1'b1, 32'sd65536},
		'{ROW_ITEM,  REG_GAIN_P,  32'h0, 32'sh8000_0000, 32'sh7fff_ffff, 31'd0, 1'b0,
			1'b1, -32'sd65536},
		'{ROW_ITEM,  REG_GAIN_P,  32'h0, 32'sd100000, 32'sd50000, 31'h7fff_ffff, 1'b1,
			1'b0, 32'sd0},
		'{ROW_ITEM,  REG_GAIN_P,  32'h0, -32'sd3, 32'sd7, 31'd1, 1'b0, 1'b0, 32'sd0},
		'{ROW_WRITE, REG_GAIN_I,  32'h7fff_ffff, 32'sd0, 32'sd0, 31'd0, 1'b0, 1'b0, 32'sd0},
		'{ROW_WRITE, REG_GAIN_D,  32'h8000_0000, 32'sd0, 32'sd0, 31'd0, 1'b0, 1'b0, 32'sd0},
		'{ROW_WRITE, REG_TAU,     32'h0, 32'sd0, 32'sd0, 31'd0, 1'b0, 1'b0, 32'sd0},
		'{ROW_WRITE, REG_FLOOR,   32'h8000_0000, 32'sd0, 32'sd0, 31'd0, 1'b0, 1'b0, 32'sd0},
		'{ROW_WRITE, REG_CEILING, 32'h7fff_ffff, 32'sd0, 32'sd0, 31'd0, 1'b0, 1'b0, 32'sd0},
		'{ROW_ITEM,  REG_GAIN_P,  32'h0, 32'sh1234_5678, -32'sd4660, 31'd0, 1'b0,
			1'b0, 32'sd0},
		'{ROW_ITEM,  REG_GAIN_P,  32'h0, 32'sh4000_0000, 32'shc000_0000, 31'h1_0000, 1'b0,
			1'b0, 32'sd0},
		'{ROW_ITEM,  REG_GAIN_P,  32'h0, -32'sd65536, 32'sd65536, 31'd0, 1'b1, 1'b0, 32'sd0},
		'{ROW_WRITE, REG_GAIN_P,  32'h8000_0000, 32'sd0, 32'sd0, 31'd0, 1'b0, 1'b0, 32'sd0},
		'{ROW_WRITE, REG_SPARE,   32'hffff_ffff, 32'sd0, 32'sd0, 31'd0, 1'b0, 1'b0, 32'sd0},
		'{ROW_ITEM,  REG_GAIN_P,  32'h0, 32'sd300, -32'sd200, 31'd0, 1'b0, 1'b0, 32'sd0},
		// floor above ceiling
		'{ROW_WRITE, REG_FLOOR,   32'h0001_0000, 32'sd0, 32'sd0, 31'd0, 1'b0, 1'b0, 32'sd0},
		'{ROW_WRITE, REG_CEILING, 32'hffff_0000, 32'sd0, 32'sd0, 31'd0, 1'b0, 1'b0, 32'sd0},
		'{ROW_ITEM,  REG_GAIN_P,  32'h0, 32'sd5, -32'sd5, 31'd0, 1'b0, 1'b0, 32'sd0},
		'{ROW_ITEM,  REG_GAIN_P,  32'h0, -32'sd70000, 32'sd70000, 31'd0, 1'b0, 1'b0, 32'sd0},
		// top data bit is dropped for the unsigned registers
		'{ROW_WRITE, REG_TAU,     32'hffff_ffff, 32'sd0, 32'sd0, 31'd0, 1'b0, 1'b0, 32'sd0},
		'{ROW_WRITE, REG_PERIOD,  32'hffff_ffff, 32'sd0, 32'sd0, 31'd0, 1'b0, 1'b0, 32'sd0},
		'{ROW_ITEM,  REG_GAIN_P,  32'h0, 32'sd1000, -32'sd1000, 31'd0, 1'b0, 1'b0, 32'sd0},
		'{ROW_WRITE, REG_GAIN_I,  32'hffff_0000, 32'sd0, 32'sd0, 31'd0, 1'b0, 1'b0, 32'sd0},
		'{ROW_WRITE, REG_GAIN_D,  32'h7fff_ffff, 32'sd0, 32'sd0, 31'd0, 1'b0, 1'b0, 32'sd0},
		'{ROW_WRITE, REG_PERIOD,  32'h1, 32'sd0, 32'sd0, 31'd0, 1'b0, 1'b0, 32'sd0},
		'{ROW_ITEM,  REG_GAIN_P,  32'h0, 32'sh7fff_ffff, 32'sh7fff_ffff, 31'd0, 1'b0,
			1'b0, 32'sd0},
		'{ROW_ITEM,  REG_GAIN_P,  32'h0, 32'sh8000_0000, 32'sh8000_0000, 31'd0, 1'b0,
			1'b0, 32'sd0},
		'{ROW_ITEM,  REG_GAIN_P,  32'h0, 32'sd65536, 32'sd0, 31'h7fff_ffff, 1'b1,
			1'b0, 32'sd0},
		'{ROW_ITEM,  REG_GAIN_P,  32'h0, -32'sd1, 32'sd1, 31'd0, 1'b0, 1'b0, 32'sd0}
	};

	// ------------------------------------------------------------------
	// drive item receiver and checker
	// ------------------------------------------------------------------
	initial begin
		int stall;
		q_t want;
		forever begin
			stall = $urandom_range(0, sink_stall_max);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (out_ch.valid !== 1'b1);
			if (drive_queue.size() == 0) begin
				$display("%0t unexpected drive item: actual %0d", $time, out_ch.drive);
				mismatches++;
			end else begin
				want = drive_queue.pop_front();
				if (out_ch.drive !== want) begin
					$display("%0t drive mismatch: expected %0d, actual %0d",
						$time, want, out_ch.drive);
					mismatches++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		int i, phase, n;
		logic writing;
		sample_t smp;
		logic [DW-1:0] fl, cl;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_GAIN_P;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.target <= '0;
		in_ch.measured <= '0;
		in_ch.new_period <= '0;
		in_ch.hold_integrator <= 1'b0;

		kp = RST_GAIN_P;
		ki = RST_GAIN_I;
		kd = RST_GAIN_D;
		tau_s = RST_TAU;
		floor_s = RST_FLOOR;
		ceil_s = RST_CEILING;
		period_cur = q_t'({1'b0, RST_PERIOD});
		integ_acc = '0;
		prev_err = '0;
		slope_acc = '0;
		prev_meas = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (SETTLE_CYCLES) @(posedge clk);

		writing = 1'b0;
		for (i = 0; i < PLAN_LEN; i++) begin
			if (plan[i].kind == ROW_WRITE) begin
				if (!writing)
					settle_block();
				writing = 1'b1;
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				if (writing)
					cfg_we <= 1'b0;
				writing = 1'b0;
				smp.target = plan[i].target;
				smp.measured = plan[i].measured;
				smp.new_period = plan[i].new_period;
				smp.hold = plan[i].hold;
				send_sample(smp, plan[i].typed, plan[i].drive);
			end
		end

		for (phase = 0; phase < PHASES; phase++) begin
			settle_block();
			src_gap_max = (phase % 3 == 0) ? 0 : 8;
			sink_stall_max = (phase % 4 == 1) ? 0 : 8;
			case ($urandom_range(0, 7))
				0: begin
					fl = Q_MIN;
					cl = Q_MAX;
				end
				1: begin
					fl = $urandom_range(0, 32'h20_0000) - 32'h10_0000;
					cl = fl;
				end
				2: begin
					fl = $urandom_range(0, 32'h20_0000);
					cl = -$urandom_range(0, 32'h20_0000);
				end
				default: begin
					fl = -$urandom_range(0, 32'h20_0000);
					cl = $urandom_range(0, 32'h20_0000);
				end
			endcase
			write_reg(REG_GAIN_P, pick_gain());
			write_reg(REG_GAIN_I, pick_gain());
			write_reg(REG_GAIN_D, pick_gain());
			write_reg(REG_TAU, pick_tau());
			write_reg(REG_FLOOR, fl);
			write_reg(REG_CEILING, cl);
			write_reg(REG_PERIOD, pick_period());
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_SPARE, $urandom());
			cfg_we <= 1'b0;
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 63) == 0)
					settle_block();
				send_sample(random_sample(), 1'b0, '0);
			end
		end

		in_ch.valid <= 1'b0;
		while (drive_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("pid_regulator_step_unit_test passed");
		else
			$display("pid_regulator_step_unit_test failed");
		$finish;
	end

endmodule
